// ----- rtl/smss_pkg.sv -----
// Package for the shutter motor stall-stop core: field widths, codes,
// state machine encoding and register indexes. No dependencies.
`timescale 1ns / 1ps

package smss_pkg;

    localparam int TIME_BITS   = 32;
    localparam int SUM_W       = 14;
    localparam int RATIO_W     = 10;
    localparam int HOLD_W      = 16;
    localparam int LEARN_W     = 4;
    localparam int WEIGHT_W    = 16;
    localparam int POS_W       = 7;
    localparam int BASE_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Learning mean divider: numerator baseline*(n-1) + delta<<10 + n/2.
    localparam int DIV_NUM_W   = 29;
    localparam int DIV_DEN_W   = 4;
    localparam int DIV_CNT_W   = 5;

    localparam int MUL_A_W     = 24;
    localparam int MUL_B_W     = 17;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam logic [POS_W-1:0] FULL_POS = POS_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WEIGHT  = 3'd5;

    localparam logic [2:0] MODE_SAMPLE = 3'd0;
    localparam logic [2:0] MODE_UP     = 3'd1;
    localparam logic [2:0] MODE_DOWN   = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_HOME   = 3'd4;

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motion_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LEARN_MUL,
        ST_LEARN_ADD,
        ST_DIV_WAIT,
        ST_RATIO1,
        ST_CMP1,
        ST_TRACK_A,
        ST_TRACK_B,
        ST_TRACK_SUM,
        ST_RATIO2,
        ST_CMP2,
        ST_TIMER,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/shutter_motor_stall_stop_core.sv -----
// Top level of the shutter motor stall-stop core: request handshake, config
// registers, motion state and the multiply sequencer. Depends on smss_pkg
// and smss_div.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one request per item. s_tuser carries the mode
//   (sample, up, down, stop, home); s_tdata carries sample_sum, time_ms and
//   home_position. Result channel m_*: exactly one result per request,
//   showing motion, relays, position and the end/reject flags.
//   Config port: write cfg_wdata into register cfg_index while cfg_we is
//   high; only while the block is idle. Unknown indexes are ignored.
// Sequencing
//   One request is processed at a time; s_tready is high only when the
//   sequencer is idle and out of reset. Commands and samples that stop early
//   (motor idle, current at or below threshold) pass ST_DECODE, ST_EMIT.
//   A stall check runs ST_RATIO1, ST_CMP1 (tracking: ST_TRACK_A, ST_TRACK_B,
//   ST_TRACK_SUM, ST_RATIO2, ST_CMP2), then ST_TIMER if over. Learning waits
//   in ST_DIV_WAIT on the serial divider, one quotient bit at a time. All
//   products share one 24x17 multiplier with a registered output.
// Reset and stall
//   aresetn (synchronous, active low) sets the motor idle, position 0 and
//   unknown, clears baseline and timer and loads the config defaults.
//   A finished result waits in the output register while m_tready is low;
//   the sequencer still takes the next request and holds its result until
//   the output register frees up.
module shutter_motor_stall_stop_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [55:0]                       s_tdata,  // sample_sum, time_ms, home_position
    input  logic [2:0]                        s_tuser,  // mode
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // motion, relay_enable, relay_up,
                                                        // travel_position, travel_known,
                                                        // end_reached, home_rejected
    // configuration write port
    input  logic                              cfg_we,
    input  logic [smss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import smss_pkg::*;

    // configuration registers
    logic [SUM_W-1:0]    zero_offset_reg;
    logic [SUM_W-1:0]    run_threshold_reg;
    logic [RATIO_W-1:0]  stall_ratio_reg;
    logic [HOLD_W-1:0]   hold_time_reg;
    logic [LEARN_W-1:0]  learn_count_reg;
    logic [WEIGHT_W-1:0] track_weight_reg;

    // control and block state
    seq_state_t          state_reg, state_next;
    motion_t             motion_reg, motion_next;
    logic [POS_W-1:0]    place_reg, place_next;
    logic                known_reg, known_next;
    logic [BASE_W-1:0]   baseline_reg, baseline_next;
    logic [LEARN_W-1:0]  learned_reg, learned_next;
    logic                timing_reg, timing_next;
    logic [TIME_BITS-1:0] since_reg, since_next;
    logic                ended_reg, ended_next;
    logic                rejected_reg, rejected_next;
    logic                m_valid_reg, m_valid_next;

    // payload registers
    logic [2:0]          mode_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [POS_W-1:0]    home_reg;
    logic [SUM_W-1:0]    delta_reg, delta_next;
    logic [MUL_P_W-1:0]  prod_reg;
    logic [MUL_P_W-1:0]  acc_reg, acc_next;
    logic [15:0]         m_data_reg, m_data_next;

    // shared multiplier operands
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;

    // divider
    logic                div_start;
    logic [DIV_NUM_W-1:0] div_numer;
    logic [DIV_NUM_W-1:0] div_quot;
    div_status_t         div_stat;

    // helpers
    logic                in_accept;
    logic [SUM_W:0]      delta_full;
    logic                below_run;
    logic [LEARN_W-1:0]  n_cur;
    logic [BASE_W-1:0]   d10;
    logic [33:0]         delta_q22;
    logic                over;
    logic [TIME_BITS-1:0] elapsed;
    logic [MUL_P_W:0]    track_sum;
    logic                out_free;

    assign in_accept  = s_tvalid && s_tready;
    assign s_tready   = aresetn && (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_tready;

    assign delta_full = {1'b0, sum_reg} - {1'b0, zero_offset_reg};
    assign below_run  = delta_full[SUM_W] || (delta_full[SUM_W-1:0] <= run_threshold_reg);
    assign n_cur      = learned_reg + 1'b1;
    assign d10        = {delta_reg, 10'b0};
    assign delta_q22  = {2'b0, delta_reg, 18'b0};
    assign over       = delta_q22 > prod_reg[33:0];
    assign elapsed    = time_reg - since_reg;
    assign track_sum  = {1'b0, acc_reg} + {1'b0, prod_reg} + (MUL_P_W + 1)'(32768);

    // learning numerator: baseline*(n-1) + delta<<10 + n/2
    assign div_numer  = {1'b0, prod_reg[27:0]} + {5'b0, d10}
                      + {{(DIV_NUM_W-3){1'b0}}, n_cur[LEARN_W-1:1]};
    assign div_start  = (state_reg == ST_LEARN_ADD);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = baseline_reg;
        mul_b = {{(MUL_B_W-RATIO_W){1'b0}}, stall_ratio_reg};
        case (state_reg)
            ST_LEARN_MUL: mul_b = {{(MUL_B_W-LEARN_W){1'b0}}, learned_reg};
            ST_TRACK_A:   mul_b = MUL_B_W'(17'h10000) - {1'b0, track_weight_reg};
            ST_TRACK_B: begin
                mul_a = d10;
                mul_b = {1'b0, track_weight_reg};
            end
            default: ;
        endcase
    end

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    smss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (n_cur),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // sequencer: next state and block state updates
    always_comb begin
        state_next    = state_reg;
        motion_next   = motion_reg;
        place_next    = place_reg;
        known_next    = known_reg;
        baseline_next = baseline_reg;
        learned_next  = learned_reg;
        timing_next   = timing_reg;
        since_next    = since_reg;
        ended_next    = ended_reg;
        rejected_next = rejected_reg;
        delta_next    = delta_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        // drop the pending result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ended_next    = 1'b0;
                    rejected_next = 1'b0;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EMIT;
                unique case (mode_reg) inside
                    MODE_SAMPLE: begin
                        delta_next = delta_full[SUM_W-1:0];
                        if (motion_reg == MOT_IDLE) begin
                            baseline_next = '0;
                            learned_next  = '0;
                            timing_next   = 1'b0;
                            since_next    = '0;
                        end else if (below_run) begin
                            timing_next = 1'b0;
                            since_next  = '0;
                        end else if (learned_reg < learn_count_reg) begin
                            state_next = ST_LEARN_MUL;
                        end else begin
                            state_next = ST_RATIO1;
                        end
                    end
                    MODE_UP, MODE_DOWN: begin
                        if (motion_reg != ((mode_reg == MODE_UP) ? MOT_UP : MOT_DOWN)) begin
                            motion_next   = (mode_reg == MODE_UP) ? MOT_UP : MOT_DOWN;
                            timing_next   = 1'b0;
                            since_next    = '0;
                            baseline_next = '0;
                            learned_next  = '0;
                        end
                    end
                    MODE_STOP: begin
                        motion_next = MOT_IDLE;
                        timing_next = 1'b0;
                        since_next  = '0;
                    end
                    MODE_HOME: begin
                        if (home_reg > FULL_POS) begin
                            rejected_next = 1'b1;
                        end else begin
                            place_next = home_reg;
                            known_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_LEARN_MUL: state_next = ST_LEARN_ADD;
            ST_LEARN_ADD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    baseline_next = div_quot[BASE_W-1:0];
                    learned_next  = n_cur;
                    state_next    = ST_EMIT;
                end
            end
            ST_RATIO1: state_next = ST_CMP1;
            ST_CMP1: begin
                state_next = over ? ST_TIMER : ST_TRACK_A;
            end
            ST_TRACK_A: state_next = ST_TRACK_B;
            ST_TRACK_B: begin
                acc_next   = prod_reg;
                state_next = ST_TRACK_SUM;
            end
            ST_TRACK_SUM: begin
                baseline_next = track_sum[39:16];
                state_next    = ST_RATIO2;
            end
            ST_RATIO2: state_next = ST_CMP2;
            ST_CMP2: begin
                if (over) begin
                    state_next = ST_TIMER;
                end else begin
                    timing_next = 1'b0;
                    since_next  = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_TIMER: begin
                state_next = ST_EMIT;
                if (!timing_reg) begin
                    timing_next = 1'b1;
                    since_next  = time_reg;
                end else if (elapsed >= {{(TIME_BITS-HOLD_W){1'b0}}, hold_time_reg}) begin
                    // end of travel: stop and mark the position
                    place_next  = (motion_reg == MOT_UP) ? FULL_POS : '0;
                    known_next  = 1'b1;
                    motion_next = MOT_IDLE;
                    timing_next = 1'b0;
                    since_next  = '0;
                    ended_next  = 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b0, rejected_reg, ended_reg, known_reg, place_reg,
                                    (motion_reg == MOT_UP), (motion_reg != MOT_IDLE),
                                    motion_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            motion_reg   <= MOT_IDLE;
            place_reg    <= '0;
            known_reg    <= 1'b0;
            baseline_reg <= '0;
            learned_reg  <= '0;
            timing_reg   <= 1'b0;
            since_reg    <= '0;
            ended_reg    <= 1'b0;
            rejected_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            motion_reg   <= motion_next;
            place_reg    <= place_next;
            known_reg    <= known_next;
            baseline_reg <= baseline_next;
            learned_reg  <= learned_next;
            timing_reg   <= timing_next;
            since_reg    <= since_next;
            ended_reg    <= ended_next;
            rejected_reg <= rejected_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg   <= SUM_W'(0);
            run_threshold_reg <= SUM_W'(480);
            stall_ratio_reg   <= RATIO_W'(410);
            hold_time_reg     <= HOLD_W'(400);
            learn_count_reg   <= LEARN_W'(8);
            track_weight_reg  <= WEIGHT_W'(3277);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ZERO_OFFSET:   zero_offset_reg   <= cfg_wdata[SUM_W-1:0];
                CFG_RUN_THRESHOLD: run_threshold_reg <= cfg_wdata[SUM_W-1:0];
                CFG_STALL_RATIO:   stall_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                CFG_HOLD_TIME:     hold_time_reg     <= cfg_wdata[HOLD_W-1:0];
                CFG_LEARN_COUNT:   learn_count_reg   <= cfg_wdata[LEARN_W-1:0];
                CFG_TRACK_WEIGHT:  track_weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // payload: capture the request, register the product
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg <= s_tuser;
            sum_reg  <= s_tdata[13:0];
            time_reg <= s_tdata[45:14];
            home_reg <= s_tdata[52:46];
        end
        prod_reg   <= mul_p;
        acc_reg    <= acc_next;
        delta_reg  <= delta_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/smss_div.sv -----
// Restoring divider for the learning mean, one quotient bit per cycle.
// Depends on smss_pkg.
`timescale 1ns / 1ps

module smss_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [smss_pkg::DIV_NUM_W-1:0] numer,
    input  logic [smss_pkg::DIV_DEN_W-1:0] denom,
    output logic [smss_pkg::DIV_NUM_W-1:0] quotient,
    output smss_pkg::div_status_t         status
);
    import smss_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end else if (busy_reg) begin
            // shift in the next numerator bit, subtract when it fits
            if (!trial[DIV_DEN_W]) begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
